@@ hw/rtl/hhe_pkg.sv @@
// Shared types, character codes and helpers for the HTTP host header extractor.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package hhe_pkg;

  // character codes used by the parser
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CASE_OFS = 8'd32;

  // match positions of the newline-host-colon pattern
  localparam logic [2:0] POS_LF    = 3'd0;
  localparam logic [2:0] POS_H     = 3'd1;
  localparam logic [2:0] POS_O     = 3'd2;
  localparam logic [2:0] POS_S     = 3'd3;
  localparam logic [2:0] POS_T     = 3'd4;
  localparam logic [2:0] POS_COLON = 3'd5;

  // result kinds
  localparam logic KIND_HOST = 1'b0;
  localparam logic KIND_STAT = 1'b1;

  // register reset value and result queue depth
  localparam logic [7:0] MAX_HOST_LEN_RST = 8'd255;
  localparam int         RQ_DEPTH_DEF     = 4;

  // parse phase, one-hot
  typedef enum logic [4:0] {
    PH_SEARCH  = 5'b00001,
    PH_BLANKS  = 5'b00010,
    PH_PLAIN   = 5'b00100,
    PH_BRACKET = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  // one result item
  typedef struct packed {
    logic       kind;
    logic [7:0] host_byte;
    logic       found;
    logic [7:0] host_length;
    logic       last;
  } res_t;

  // results produced by one request: count, then up to two items in order
  typedef struct packed {
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } push_t;

  // ascii upper case to lower case, other bytes unchanged
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UC_A && c <= CH_UC_Z) begin
      r = c + CASE_OFS;
    end
    return r;
  endfunction

  // does byte c continue the pattern at position pos
  function automatic logic pattern_hit(input logic [2:0] pos, input logic [7:0] c);
    logic hit;
    case (pos)
      POS_LF:  hit = (c == CH_LF);
      POS_H:   hit = (fold(c) == CH_LC_H);
      POS_O:   hit = (fold(c) == CH_LC_O);
      POS_S:   hit = (fold(c) == CH_LC_S);
      POS_T:   hit = (fold(c) == CH_LC_T);
      default: hit = (c == CH_COLON);
    endcase
    return hit;
  endfunction

endpackage

@@ hw/rtl/hhe_if.sv @@
// Valid/ready channel interfaces for the host header extractor.
// Depends on nothing; one interface for the byte requests, one for results.
`timescale 1ns / 1ps

interface hhe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface hhe_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] host_byte;
  logic       found;
  logic [7:0] host_length;
  logic       last;

  modport source (output valid, output kind, output host_byte, output found,
                  output host_length, output last, input ready);
  modport sink   (input valid, input kind, input host_byte, input found,
                  input host_length, input last, output ready);
endinterface

@@ hw/rtl/http_host_header_extractor_core.sv @@
// Top level of the HTTP host header extractor: register, parser and result queue.
// Depends on hhe_pkg, hhe_in_if, hhe_out_if, hhe_parse and hhe_rq.
//
// Usage
//   in_chan carries one packet byte per request, end_of_data high on the last.
//   out_chan returns lowercased host bytes (kind 0) and, on the last byte of
//   each packet, one final status (kind 1, last 1) with found and host_length.
//   cfg_we/cfg_wdata write max_host_len (reset 255); write it between packets.
// Flow
//   A byte request is parsed in the cycle it is accepted; its results are
//   registered in the result queue and leave it on out_chan in order.
//   A byte gives at most two results, so a last byte that also ends with a
//   host byte gives two output items; the result queue (RQ_DEPTH entries)
//   absorbs that; a byte is accepted every cycle while it has room for two.
// Reset and stall
//   rst_n (synchronous, active low) empties the queue, restarts the search
//   and sets max_host_len to 255. When out_chan stalls, results wait in the
//   queue and in_chan.ready drops once fewer than two entries are free.
`timescale 1ns / 1ps

module http_host_header_extractor_core #(
  parameter int RQ_DEPTH = hhe_pkg::RQ_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  hhe_in_if.sink           in_chan,
  hhe_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_wdata
);
  import hhe_pkg::*;

  logic [7:0] max_host_len_r;
  logic       in_accept;
  logic       space2;
  logic       head_vld;
  res_t       head;
  push_t      push;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_host_len_r <= MAX_HOST_LEN_RST;
    end else if (cfg_we) begin
      max_host_len_r <= cfg_wdata;
    end
  end

  // input handshake
  assign in_chan.ready = space2;
  assign in_accept     = in_chan.valid && space2;

  // byte parser
  hhe_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .data_byte    (in_chan.data_byte),
    .end_of_data  (in_chan.end_of_data),
    .max_host_len (max_host_len_r),
    .push         (push)
  );

  // result queue
  hhe_rq #(
    .RQ_DEPTH (RQ_DEPTH)
  ) u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_chan.ready),
    .space2   (space2),
    .head_vld (head_vld),
    .head     (head)
  );

  // output channel
  assign out_chan.valid       = head_vld;
  assign out_chan.kind        = head.kind;
  assign out_chan.host_byte   = head.host_byte;
  assign out_chan.found       = head.found;
  assign out_chan.host_length = head.host_length;
  assign out_chan.last        = head.last;

endmodule

@@ hw/rtl/hhe_parse.sv @@
// Per-byte parser state machine: pattern match, blank skip, host capture.
// Depends on hhe_pkg; hands the results of each request to the result queue.
`timescale 1ns / 1ps

module hhe_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     data_byte,
  input  logic           end_of_data,
  input  logic [7:0]     max_host_len,
  output hhe_pkg::push_t push
);
  import hhe_pkg::*;

  logic [2:0] match_pos_r, match_pos_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] emitted_r, emitted_nxt;
  logic       host_seen_r, host_seen_nxt;
  logic       put_host;
  logic       emit;
  logic       term_plain;
  logic       crlf;
  res_t       host_res;
  res_t       stat_res;

  assign crlf       = (data_byte == CH_CR) || (data_byte == CH_LF);
  assign term_plain = crlf || (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                      (data_byte == CH_COLON);

  // next state for one byte
  always_comb begin
    match_pos_nxt = match_pos_r;
    phase_nxt     = phase_r;
    host_seen_nxt = host_seen_r;
    put_host      = 1'b0;
    case (phase_r)
      PH_SEARCH: begin
        if (pattern_hit(match_pos_r, data_byte)) begin
          if (match_pos_r == POS_COLON) begin
            match_pos_nxt = POS_LF;
            phase_nxt     = PH_BLANKS;
          end else begin
            match_pos_nxt = match_pos_r + 3'd1;
          end
        end else begin
          match_pos_nxt = (data_byte == CH_LF) ? POS_H : POS_LF;
        end
      end
      PH_BLANKS: begin
        if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
          phase_nxt = PH_BLANKS;
        end else if (data_byte == CH_LBRK) begin
          host_seen_nxt = 1'b1;
          phase_nxt     = PH_BRACKET;
          put_host      = 1'b1;
        end else if (crlf || data_byte == CH_COLON) begin
          phase_nxt = PH_DONE;
        end else begin
          host_seen_nxt = 1'b1;
          phase_nxt     = PH_PLAIN;
          put_host      = 1'b1;
        end
      end
      PH_PLAIN: begin
        if (term_plain) begin
          phase_nxt = PH_DONE;
        end else begin
          put_host = 1'b1;
        end
      end
      PH_BRACKET: begin
        if (crlf) begin
          phase_nxt = PH_DONE;
        end else begin
          put_host = 1'b1;
          if (data_byte == CH_RBRK) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  // length limit on emitted host bytes
  assign emit        = put_host && (emitted_r < max_host_len);
  assign emitted_nxt = emitted_r + {7'd0, emit};

  // result items
  always_comb begin
    host_res             = '0;
    host_res.kind        = KIND_HOST;
    host_res.host_byte   = fold(data_byte);
    stat_res             = '0;
    stat_res.kind        = KIND_STAT;
    stat_res.found       = host_seen_nxt;
    stat_res.host_length = emitted_nxt;
    stat_res.last        = 1'b1;
    push.n      = accept ? ({1'b0, emit} + {1'b0, end_of_data}) : 2'd0;
    push.first  = emit ? host_res : stat_res;
    push.second = stat_res;
  end

  // state registers, cleared after the final status of a packet
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_pos_r <= POS_LF;
      phase_r     <= PH_SEARCH;
      emitted_r   <= 8'd0;
      host_seen_r <= 1'b0;
    end else if (accept) begin
      if (end_of_data) begin
        match_pos_r <= POS_LF;
        phase_r     <= PH_SEARCH;
        emitted_r   <= 8'd0;
        host_seen_r <= 1'b0;
      end else begin
        match_pos_r <= match_pos_nxt;
        phase_r     <= phase_nxt;
        emitted_r   <= emitted_nxt;
        host_seen_r <= host_seen_nxt;
      end
    end
  end

  // no host bytes counted before a host has started
  a_no_count_without_host: assert property (@(posedge clk) disable iff (!rst_n)
    !host_seen_r |-> (emitted_r == 8'd0))
    else $error("host bytes counted before a host started");

  // while searching nothing of a host is known
  a_search_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SEARCH) |-> !host_seen_r)
    else $error("host marked seen while still searching");

  // the last byte of a packet returns the parser to its start
  a_eod_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && end_of_data) |=>
      (phase_r == PH_SEARCH && match_pos_r == POS_LF && emitted_r == 8'd0))
    else $error("parser state not cleared after end of data");

endmodule

@@ hw/rtl/hhe_rq.sv @@
// Result queue: up to two results in per request; one out per cycle while popped.
// Depends on hhe_pkg; entries sit at fixed places and shift towards the head.
`timescale 1ns / 1ps

module hhe_rq #(
  parameter int RQ_DEPTH = hhe_pkg::RQ_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hhe_pkg::push_t push,
  input  logic           pop,
  output logic           space2,
  output logic           head_vld,
  output hhe_pkg::res_t  head
);
  import hhe_pkg::*;

  localparam int CNT_W = $clog2(RQ_DEPTH + 1);

  res_t             ent_r   [RQ_DEPTH];
  res_t             ent_nxt [RQ_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cnt_pop;
  logic             do_pop;

  assign do_pop   = pop && (count_r != '0);
  assign cnt_pop  = count_r - {{(CNT_W-1){1'b0}}, do_pop};
  assign head_vld = (count_r != '0);
  assign head     = ent_r[0];
  assign space2   = (count_r <= CNT_W'(RQ_DEPTH - 2));

  // shift out the head, then append the new results behind what is left
  always_comb begin
    for (int i = 0; i < RQ_DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    if (do_pop) begin
      for (int i = 0; i < RQ_DEPTH - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
    end
    for (int i = 0; i < RQ_DEPTH; i++) begin
      if (push.n != 2'd0 && CNT_W'(i) == cnt_pop) begin
        ent_nxt[i] = push.first;
      end
      if (push.n == 2'd2 && CNT_W'(i) == cnt_pop + CNT_W'(1)) begin
        ent_nxt[i] = push.second;
      end
    end
    count_nxt = cnt_pop + CNT_W'(push.n);
  end

  // entry payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < RQ_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // fill count stays within the queue
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RQ_DEPTH))
    else $error("result queue count beyond depth");

  // results only arrive when there is room for them
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> ({1'b0, cnt_pop} + (CNT_W+1)'(push.n) <= (CNT_W+1)'(RQ_DEPTH)))
    else $error("result queue overflow");

  // a pop with nothing pushed drops the count by one
  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && push.n == 2'd0) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("result queue count wrong after pop");

endmodule
